### hw/rtl/cftm_pkg.sv
// Shared constants for the cron field text-to-mask parser.
`timescale 1ns / 1ps

package cftm_pkg;

    localparam int MASK_BITS_DEF = 64;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [7:0] REG_FIELD_LOW  = 8'd0;
    localparam logic [7:0] REG_FIELD_HIGH = 8'd1;

    localparam logic [8:0] VALUE_SAT = 9'd256;
    localparam logic [8:0] VALUE_MAX = 9'd255;

endpackage

### hw/rtl/cron_field_text_to_mask.sv
// Cron field parser: character stream in, selection mask and status out.
`timescale 1ns / 1ps
//
// channel | dir | handshake                   | word
// s_axis  | in  | s_axis_tvalid/s_axis_tready | ch
// m_axis  | out | m_axis_tvalid/m_axis_tready | field_mask, status
// cfg     | in  | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// One character per cycle while s_axis_tready is high; parse state updates in the cycle a word is accepted.
// A NUL pushes its result into the output register, or into the skid entry while the output is stalled.
// A two-entry output (register plus skid) keeps input flowing while one result waits.
// Input stalls only when both output entries are full. cfg_ready is always high.
// aresetn is synchronous: clears parse state, output valids, field_low=0, field_high=59.

module cron_field_text_to_mask #(
    parameter int MASK_BITS = cftm_pkg::MASK_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [7:0] ch
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [MASK_BITS-1:0] field_mask, [MASK_BITS+1:MASK_BITS] status, zero pad
    output logic [((MASK_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [7:0]                            cfg_index,
    input  logic [7:0]                            cfg_data
);
    import cftm_pkg::*;

    localparam int TDATA_W = ((MASK_BITS + 2 + 7) / 8) * 8;
    localparam logic [8:0] SPAN_MAX = 9'(MASK_BITS - 1);

    typedef enum logic [5:0] {
        PH_FIRST       = 6'b000001,
        PH_START_DIGIT = 6'b000010,
        PH_IN_START    = 6'b000100,
        PH_END_DIGIT   = 6'b001000,
        PH_IN_END      = 6'b010000,
        PH_STOPPED     = 6'b100000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [8:0]             start_reg, start_next;
    logic [8:0]             end_reg, end_next;
    logic [MASK_BITS-1:0]   mask_reg, mask_next;
    logic                   err_reg, err_next;
    logic [7:0]             low_reg, high_reg;

    logic [MASK_BITS-1:0]   out_mask_reg, skid_mask_reg;
    logic [1:0]             out_status_reg, skid_status_reg;
    logic                   out_valid_reg, skid_valid_reg;

    logic [7:0]             ch;
    logic                   in_acc, is_dig;
    logic [3:0]             dig;
    logic [8:0]             c_s, c_e, s_idx, e_idx, star_n;
    logic                   c_ok;
    logic [MASK_BITS-1:0]   c_bits, star_bits;
    logic                   push;
    logic [MASK_BITS-1:0]   res_mask;
    logic [1:0]             res_status;

    function automatic logic [8:0] add_digit(input logic [8:0] v, input logic [3:0] d);
        logic [12:0] r;
        r = 13'({v, 3'b000}) + 13'({v, 1'b0}) + 13'(d);
        return (r > 13'(VALUE_MAX)) ? VALUE_SAT : r[8:0];
    endfunction

    assign ch            = s_axis_tdata;
    assign s_axis_tready = !skid_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_dig        = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign dig           = ch[3:0];
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'({out_status_reg, out_mask_reg});

    // range check and bit span for the item being closed
    assign c_s   = start_reg;
    assign c_e   = (phase_reg == PH_IN_END) ? end_reg : start_reg;
    assign s_idx = c_s - 9'(low_reg);
    assign e_idx = c_e - 9'(low_reg);
    assign c_ok  = (low_reg <= high_reg)
                && ((9'(high_reg) - 9'(low_reg)) <= SPAN_MAX)
                && (c_s >= 9'(low_reg))
                && (c_e >= c_s)
                && (c_e <= 9'(high_reg));
    assign star_n = (high_reg >= low_reg) ? (9'(high_reg) - 9'(low_reg) + 9'd1) : 9'd0;

    always_comb begin
        for (int i = 0; i < MASK_BITS; i++) begin
            c_bits[i]    = (9'(i) >= s_idx) && (9'(i) <= e_idx);
            star_bits[i] = 9'(i) < star_n;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        start_next = start_reg;
        end_next   = end_reg;
        mask_next  = mask_reg;
        err_next   = err_reg;
        push       = 1'b0;
        res_mask   = '0;
        res_status = ST_OK;
        if (in_acc) begin
            if (ch == CH_NUL) begin
                push = 1'b1;
                case (phase_reg)
                    PH_FIRST: begin
                        res_status = ST_EMPTY;
                    end
                    PH_START_DIGIT, PH_END_DIGIT: begin
                        res_status = ST_BAD;
                    end
                    PH_IN_START, PH_IN_END: begin
                        res_status = c_ok ? ST_OK : ST_BAD;
                        res_mask   = c_ok ? (mask_reg | c_bits) : '0;
                    end
                    default: begin
                        res_status = err_reg ? ST_BAD : ST_OK;
                        res_mask   = err_reg ? '0 : mask_reg;
                    end
                endcase
                phase_next = PH_FIRST;
                start_next = '0;
                end_next   = '0;
                mask_next  = '0;
                err_next   = 1'b0;
            end else begin
                case (phase_reg)
                    PH_FIRST: begin
                        if (ch == CH_STAR) begin
                            mask_next  = star_bits;
                            phase_next = PH_STOPPED;
                        end else if (is_dig) begin
                            start_next = 9'(dig);
                            phase_next = PH_IN_START;
                        end else begin
                            err_next   = 1'b1;
                            phase_next = PH_STOPPED;
                        end
                    end
                    PH_START_DIGIT: begin
                        if (is_dig) begin
                            start_next = 9'(dig);
                            phase_next = PH_IN_START;
                        end else begin
                            err_next   = 1'b1;
                            phase_next = PH_STOPPED;
                        end
                    end
                    PH_END_DIGIT: begin
                        if (is_dig) begin
                            end_next   = 9'(dig);
                            phase_next = PH_IN_END;
                        end else begin
                            err_next   = 1'b1;
                            phase_next = PH_STOPPED;
                        end
                    end
                    PH_IN_START, PH_IN_END: begin
                        if (is_dig) begin
                            if (phase_reg == PH_IN_START) begin
                                start_next = add_digit(start_reg, dig);
                            end else begin
                                end_next = add_digit(end_reg, dig);
                            end
                        end else if (ch == CH_DASH && phase_reg == PH_IN_START) begin
                            phase_next = PH_END_DIGIT;
                        end else begin
                            if (c_ok) begin
                                mask_next = mask_reg | c_bits;
                            end
                            if (c_ok && ch == CH_COMMA) begin
                                phase_next = PH_START_DIGIT;
                            end else begin
                                err_next   = err_reg || !c_ok;
                                phase_next = PH_STOPPED;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            start_reg <= '0;
            end_reg   <= '0;
            mask_reg  <= '0;
            err_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            mask_reg  <= mask_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= 8'd0;
            high_reg <= 8'd59;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FIELD_LOW) begin
                low_reg <= cfg_data;
            end else if (cfg_index == REG_FIELD_HIGH) begin
                high_reg <= cfg_data;
            end
        end
    end

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_axis_tready) begin
            if (skid_valid_reg) begin
                out_mask_reg   <= skid_mask_reg;
                out_status_reg <= skid_status_reg;
            end else if (push) begin
                out_mask_reg   <= res_mask;
                out_status_reg <= res_status;
            end
        end else if (push) begin
            skid_mask_reg   <= res_mask;
            skid_status_reg <= res_status;
        end
    end

endmodule

### hw/rtl/cftm_checker.sv
// Port-level checker for the cron field parser, bound to the top level.
`timescale 1ns / 1ps

module cftm_checker #(
    parameter int MASK_BITS = cftm_pkg::MASK_BITS_DEF
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic [7:0]                            s_axis_tdata,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((MASK_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic [7:0]                            cfg_index,
    input logic [7:0]                            cfg_data
);
    import cftm_pkg::*;

    logic [1:0]           st;
    logic [MASK_BITS-1:0] mask;

    assign st   = m_axis_tdata[MASK_BITS+1:MASK_BITS];
    assign mask = m_axis_tdata[MASK_BITS-1:0];

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (st == ST_OK || st == ST_EMPTY || st == ST_BAD))
        else $error("undefined status code");

    a_fail_no_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st != ST_OK |-> mask == '0)
        else $error("mask set on failed or empty field");

endmodule

bind cron_field_text_to_mask cftm_checker #(.MASK_BITS(MASK_BITS)) u_cftm_checker (.*);

### tb/cron_field_text_to_mask_test.sv
// Self-checking testbench: cron field character stream against a predicted mask and status.
`timescale 1ns / 1ps

module cron_field_text_to_mask_test;
    import cftm_pkg::*;

    typedef enum logic [2:0] {
        AT_FIRST,
        WANT_START,
        IN_START,
        WANT_END,
        IN_END,
        HALTED
    } parse_phase_t;

    typedef struct packed {
        logic [63:0] mask;
        logic [1:0]  status;
    } field_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] ch
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;           // [63:0] field_mask, [65:64] status, zero pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'h00;
    logic [7:0]  cfg_data = 8'h00;

    parse_phase_t  pr_phase;
    logic [8:0]    pr_start;
    logic [8:0]    pr_end;
    logic [63:0]   pr_mask;
    logic          pr_bad;
    logic [7:0]    pr_low;
    logic [7:0]    pr_high;
    field_result_t mask_results[$];

    logic [7:0]  text_q[$];
    int unsigned cur_lo = 0;
    int unsigned cur_hi = 59;
    int unsigned chars_sent = 0;
    int unsigned errors = 0;
    bit          steady = 1'b0;

    cron_field_text_to_mask u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] low_bits(input int unsigned n);
        if (n >= 64) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [8:0] push_digit(input logic [8:0] v, input logic [7:0] c);
        int unsigned r;
        r = int'(v) * 10 + int'(c) - int'(CH_ZERO);
        return (r > int'(VALUE_MAX)) ? VALUE_SAT : r[8:0];
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit take_span(input int unsigned s, input int unsigned e);
        int unsigned lo;
        int unsigned hi;
        lo = pr_low;
        hi = pr_high;
        if (lo > hi) return 1'b0;
        if (hi - lo > MASK_BITS_DEF - 1) return 1'b0;
        if (s < lo || e < s || e > hi) return 1'b0;
        pr_mask = pr_mask | (low_bits(e - lo + 1) & ~low_bits(s - lo));
        return 1'b1;
    endfunction

    task automatic clear_parser();
        pr_phase = AT_FIRST;
        pr_start = '0;
        pr_end = '0;
        pr_mask = '0;
        pr_bad = 1'b0;
    endtask

    task automatic halt_parser(input bit bad);
        pr_bad = pr_bad | bad;
        pr_phase = HALTED;
    endtask

    task automatic advance_parser(input logic [7:0] c);
        field_result_t r;
        logic [1:0]    st;
        int unsigned   n;
        bit            ok;
        if (c == CH_NUL) begin
            case (pr_phase)
                AT_FIRST: st = ST_EMPTY;
                WANT_START, WANT_END: st = ST_BAD;
                IN_START: st = take_span(pr_start, pr_start) ? ST_OK : ST_BAD;
                IN_END: st = take_span(pr_start, pr_end) ? ST_OK : ST_BAD;
                default: st = pr_bad ? ST_BAD : ST_OK;
            endcase
            r.mask = (st == ST_OK) ? pr_mask : '0;
            r.status = st;
            mask_results.push_back(r);
            clear_parser();
        end else begin
            case (pr_phase)
                AT_FIRST: begin
                    if (c == CH_STAR) begin
                        n = (pr_high >= pr_low) ? int'(pr_high) - int'(pr_low) + 1 : 0;
                        if (n > MASK_BITS_DEF) n = MASK_BITS_DEF;
                        pr_mask = low_bits(n);
                        halt_parser(1'b0);
                    end else if (is_digit(c)) begin
                        pr_start = 9'(c - CH_ZERO);
                        pr_phase = IN_START;
                    end else begin
                        halt_parser(1'b1);
                    end
                end
                WANT_START: begin
                    if (is_digit(c)) begin
                        pr_start = 9'(c - CH_ZERO);
                        pr_phase = IN_START;
                    end else begin
                        halt_parser(1'b1);
                    end
                end
                IN_START: begin
                    if (is_digit(c)) begin
                        pr_start = push_digit(pr_start, c);
                    end else if (c == CH_DASH) begin
                        pr_phase = WANT_END;
                    end else begin
                        ok = take_span(pr_start, pr_start);
                        if (ok && c == CH_COMMA) pr_phase = WANT_START;
                        else halt_parser(!ok);
                    end
                end
                WANT_END: begin
                    if (is_digit(c)) begin
                        pr_end = 9'(c - CH_ZERO);
                        pr_phase = IN_END;
                    end else begin
                        halt_parser(1'b1);
                    end
                end
                IN_END: begin
                    if (is_digit(c)) begin
                        pr_end = push_digit(pr_end, c);
                    end else begin
                        ok = take_span(pr_start, pr_end);
                        if (ok && c == CH_COMMA) pr_phase = WANT_START;
                        else halt_parser(!ok);
                    end
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge aclk) begin
        field_result_t want;
        if (!aresetn) begin
            pr_low = 8'd0;
            pr_high = 8'd59;
            clear_parser();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (mask_results.size() == 0) begin
                    $display("%0t: result with nothing expected: mask %h status %0d", $time,
                             m_axis_tdata[63:0], m_axis_tdata[65:64]);
                    errors++;
                end else begin
                    want = mask_results.pop_front();
                    if (m_axis_tdata[63:0] !== want.mask) begin
                        $display("%0t: field_mask expected %h got %h", $time, want.mask,
                                 m_axis_tdata[63:0]);
                        errors++;
                    end
                    if (m_axis_tdata[65:64] !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time, want.status,
                                 m_axis_tdata[65:64]);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FIELD_LOW) pr_low = cfg_data;
                else if (cfg_index == REG_FIELD_HIGH) pr_high = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) advance_parser(s_axis_tdata);
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 6);
    end

    task automatic send_char(input logic [7:0] c);
        while (!steady && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        do @(posedge aclk); while (!s_axis_tready);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        send_char(CH_NUL);
    endtask

    task automatic send_field();
        foreach (text_q[i]) send_char(text_q[i]);
        send_char(CH_NUL);
    endtask

    task automatic add_number(input int unsigned v);
        string digits;
        digits = $sformatf("%0d", v);
        if ($urandom_range(9) == 0) text_q.push_back(CH_ZERO);
        for (int i = 0; i < digits.len(); i++) text_q.push_back(digits[i]);
    endtask

    task automatic send_span(input int unsigned a, input int unsigned b, input bit with_end);
        text_q.delete();
        add_number(a);
        if (with_end) begin
            text_q.push_back(CH_DASH);
            add_number(b);
        end
        send_field();
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (mask_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limits(input int unsigned lo, input int unsigned hi);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_FIELD_LOW;
        cfg_data <= 8'(lo);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_index <= REG_FIELD_HIGH;
        cfg_data <= 8'(hi);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    function automatic int unsigned pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return $urandom_range(300);
        if (r < 11) return $urandom_range(9999, 256);
        if (cur_lo <= cur_hi) return $urandom_range(cur_hi, cur_lo);
        return $urandom_range(255);
    endfunction

    task automatic build_list();
        int unsigned n;
        int unsigned a;
        int unsigned b;
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++) begin
            if (k > 0) text_q.push_back(CH_COMMA);
            a = pick_value();
            add_number(a);
            if ($urandom_range(9) < 4) begin
                text_q.push_back(CH_DASH);
                b = (a <= cur_hi && $urandom_range(9) != 0) ? $urandom_range(cur_hi, a)
                                                            : pick_value();
                add_number(b);
            end
        end
        if ($urandom_range(9) == 0) text_q.push_back(8'($urandom_range(255, 1)));
    endtask

    task automatic random_field();
        int unsigned r;
        int unsigned pos;
        text_q.delete();
        r = $urandom_range(99);
        if (r < 65) begin
            build_list();
        end else if (r < 72) begin
            text_q.push_back(CH_STAR);
            repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(255, 1)));
        end else if (r < 86) begin
            build_list();
            pos = $urandom_range(text_q.size() - 1);
            case ($urandom_range(2))
                0: text_q[pos] = 8'($urandom_range(255, 1));
                1: while (text_q.size() > pos) void'(text_q.pop_back());
                default: text_q.insert(pos, $urandom_range(1) ? CH_COMMA : CH_DASH);
            endcase
        end else if (r >= 90) begin
            repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255, 1)));
        end
        send_field();
    endtask

    task automatic random_limits();
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        r = $urandom_range(9);
        if (r < 6) begin
            lo = $urandom_range(255);
            hi = lo + $urandom_range(63);
            if (hi > 255) hi = 255;
        end else if (r < 8) begin
            lo = $urandom_range(255);
            hi = $urandom_range(255);
        end else begin
            lo = $urandom_range(100);
            hi = $urandom_range(255, lo + 64);
        end
        write_limits(lo, hi);
    endtask

    task automatic random_run(input int unsigned budget);
        int unsigned goal;
        goal = chars_sent + budget;
        while (chars_sent < goal) random_field();
    endtask

    task automatic test_reset_limits();
        send_text("");
        send_text("*");
        send_text("*7,x");
        send_text("0");
        send_text("59");
        send_text("60");
        send_text("0-59");
        send_text("5,10-20,33");
        send_text("7-");
        send_text("7,");
        send_text(",");
        send_text("-3");
        send_text("3-1");
        send_text("999");
        send_text("0255");
        send_text("10 5");
        send_text("1-5x9");
        send_text("1,,2");
        send_char(8'hFF);
        send_char(CH_NUL);
    endtask

    task automatic test_limit_extremes();
        int unsigned lows[7]  = '{0, 192, 0, 255, 255, 0, 200};
        int unsigned highs[7] = '{63, 255, 255, 0, 255, 0, 100};
        for (int i = 0; i < 7; i++) begin
            write_limits(lows[i], highs[i]);
            send_text("*");
            send_span(lows[i], 0, 1'b0);
            send_span(highs[i], 0, 1'b0);
            send_span(lows[i], highs[i], 1'b1);
            if (highs[i] < 255) send_span(highs[i] + 1, 0, 1'b0);
            if (lows[i] > 0) send_span(lows[i] - 1, highs[i], 1'b1);
        end
    endtask

    task automatic test_random_fields();
        repeat (4) begin
            random_limits();
            random_run(200);
        end
    endtask

    task automatic test_back_to_back();
        write_limits(0, 59);
        steady = 1'b1;
        random_run(200);
        wait_idle();
        steady = 1'b0;
    endtask

    initial begin
        #200000;
        $display("[cron_field_text_to_mask] ERROR");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_limits();
        test_limit_extremes();
        test_random_fields();
        test_back_to_back();
        wait_idle();
        repeat (6) @(negedge aclk);
        if (errors == 0) begin
            $display("[cron_field_text_to_mask] OK");
        end else begin
            $display("[cron_field_text_to_mask] ERROR");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/cftm_pkg.sv
hw/rtl/cron_field_text_to_mask.sv
hw/rtl/cftm_checker.sv
tb/cron_field_text_to_mask_test.sv
